// File: rtl/projective_warp_bilinear_resampler_defines.svh
// Assertion macros shared by the resampler RTL.
`ifndef PROJECTIVE_WARP_BILINEAR_RESAMPLER_DEFINES_SVH
`define PROJECTIVE_WARP_BILINEAR_RESAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
`define PWBR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pwbr same-cycle check failed");
`define PWBR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pwbr next-cycle check failed");
`else
`define PWBR_ASSERT_IMPL(name, ante, cons)
`define PWBR_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: rtl/pwbr_pkg.sv
// Shared types and constants for the projective warp resampler.
package pwbr_pkg;

    localparam int DEF_SRC_WIDTH   = 512;
    localparam int DEF_SRC_HEIGHT  = 512;
    localparam int DEF_OUT_MAX_DIM = 1024;

    localparam int CW     = 32;
    localparam int CFG_IW = 3;
    localparam int DIMW   = 10;
    localparam int PIXW   = 24;
    localparam int FRAC   = 16;
    localparam int PW     = 43;        // coefficient x coordinate product
    localparam int NW     = 45;        // numerator / denominator
    localparam int RW     = NW + 30;   // divider remainder
    localparam int LW     = NW + 14;   // range check width

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [CFG_IW-1:0] REG_COL_FROM_COL = 3'd0;
    localparam logic [CFG_IW-1:0] REG_COL_FROM_ROW = 3'd1;
    localparam logic [CFG_IW-1:0] REG_COL_OFFSET   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_ROW_FROM_COL = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ROW_FROM_ROW = 3'd4;
    localparam logic [CFG_IW-1:0] REG_ROW_OFFSET   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_DEN_FROM_COL = 3'd6;
    localparam logic [CFG_IW-1:0] REG_DEN_FROM_ROW = 3'd7;

    localparam logic signed [CW-1:0] COEF_ONE  = 32'sd65536;
    localparam logic signed [CW-1:0] COEF_ZERO = 32'sd0;
    localparam logic signed [NW-1:0] DEN_ONE   = NW'(1) << 30;

    typedef struct packed {
        logic signed [CW-1:0] cc;
        logic signed [CW-1:0] cr;
        logic signed [CW-1:0] co;
        logic signed [CW-1:0] rc;
        logic signed [CW-1:0] rr;
        logic signed [CW-1:0] ro;
        logic signed [CW-1:0] dc;
        logic signed [CW-1:0] dr;
    } t_coef;

    typedef struct packed {
        logic            load;
        logic            black;
        logic [DIMW-1:0] col;
        logic [DIMW-1:0] row;
        logic [PIXW-1:0] pix;
    } t_item;

endpackage

// File: rtl/pwbr_ram.sv
// Generic simple dual-port RAM with registered read.
module pwbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pwbr_div.sv
// Pipelined restoring divider, one quotient bit per stage, two axes side by side.
module pwbr_div import pwbr_pkg::*; #(
    parameter int QW  = 25,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [SBW-1:0] i_sb,
    input  logic [RW-1:0]  i_rem_x,
    input  logic [RW-1:0]  i_rem_y,
    input  logic [NW-1:0]  i_ad,
    output logic           o_vld,
    output logic [SBW-1:0] o_sb,
    output logic [QW-1:0]  o_qx,
    output logic [QW-1:0]  o_qy
);

    logic           r_vld [QW];
    logic [SBW-1:0] r_sb  [QW];
    logic [RW-1:0]  r_rx  [QW];
    logic [RW-1:0]  r_ry  [QW];
    logic [NW-1:0]  r_ad  [QW];
    logic [QW-1:0]  r_qx  [QW];
    logic [QW-1:0]  r_qy  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int B = QW - 1 - k;
        logic           v_in;
        logic [SBW-1:0] sb_in;
        logic [RW-1:0]  rx_in, ry_in, dv;
        logic [NW-1:0]  ad_in;
        logic [QW-1:0]  qx_in, qy_in;

        if (k == 0) begin : g_first
            assign v_in  = i_vld;
            assign sb_in = i_sb;
            assign rx_in = i_rem_x;
            assign ry_in = i_rem_y;
            assign ad_in = i_ad;
            assign qx_in = '0;
            assign qy_in = '0;
        end else begin : g_next
            assign v_in  = r_vld[k-1];
            assign sb_in = r_sb[k-1];
            assign rx_in = r_rx[k-1];
            assign ry_in = r_ry[k-1];
            assign ad_in = r_ad[k-1];
            assign qx_in = r_qx[k-1];
            assign qy_in = r_qy[k-1];
        end

        assign dv = RW'(ad_in) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[k] <= sb_in;
                r_ad[k] <= ad_in;
                if (rx_in >= dv) begin
                    r_rx[k] <= rx_in - dv;
                    r_qx[k] <= qx_in | (QW'(1) << B);
                end else begin
                    r_rx[k] <= rx_in;
                    r_qx[k] <= qx_in;
                end
                if (ry_in >= dv) begin
                    r_ry[k] <= ry_in - dv;
                    r_qy[k] <= qy_in | (QW'(1) << B);
                end else begin
                    r_ry[k] <= ry_in;
                    r_qy[k] <= qy_in;
                end
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_sb  = r_sb[QW-1];
    assign o_qx  = r_qx[QW-1];
    assign o_qy  = r_qy[QW-1];

endmodule

// File: rtl/pwbr_front.sv
// Input side: accepts transactions, classifies them, queues them for the datapath.
`include "projective_warp_bilinear_resampler_defines.svh"
module pwbr_front import pwbr_pkg::*; #(
    parameter int SRC_WIDTH   = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT  = DEF_SRC_HEIGHT,
    parameter int OUT_MAX_DIM = DEF_OUT_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IN_TDATA_W-1:0] i_in_data,
    input  logic                  i_in_user,
    output t_item                 o_item,
    output logic                  o_item_vld,
    input  logic                  i_pop
);

    logic [DIMW-1:0] col, row;
    logic            is_load, load_ok, dim_out, keep, push;
    t_item           item;

    t_item      r_buf [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign col     = i_in_data[9:0];
    assign row     = i_in_data[19:10];
    assign is_load = (i_in_user == OP_LOAD);
    assign load_ok = ({1'b0, col} < 11'(SRC_WIDTH)) && ({1'b0, row} < 11'(SRC_HEIGHT));
    assign dim_out = ({1'b0, col} >= 11'(OUT_MAX_DIM)) || ({1'b0, row} >= 11'(OUT_MAX_DIM));
    // loads outside the store are swallowed here
    assign keep    = !is_load || load_ok;

    always_comb begin
        item       = '0;
        item.load  = is_load;
        item.black = !is_load && dim_out;
        item.col   = col;
        item.row   = row;
        item.pix   = i_in_data[43:20];
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= item;
        end
    end

    assign o_item     = r_buf[r_rd];
    assign o_item_vld = (r_cnt != 2'd0);

    `PWBR_ASSERT_IMPL(a_pop_nonempty, i_pop, r_cnt != 2'd0)
    `PWBR_ASSERT_NEXT(a_cnt_up, push && !i_pop, r_cnt == $past(r_cnt) + 2'd1)
    `PWBR_ASSERT_NEXT(a_cnt_down, i_pop && !push, r_cnt == $past(r_cnt) - 2'd1)

endmodule

// File: rtl/pwbr_core.sv
// Datapath: homography, per-axis division, banked source store, bilinear blend.
`include "projective_warp_bilinear_resampler_defines.svh"
module pwbr_core import pwbr_pkg::*; #(
    parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = DEF_SRC_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_coef                  i_coef,
    input  t_item                  i_item,
    input  logic                   i_item_vld,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic                   o_out_user
);

    localparam int DIM_MAX    = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int IXW        = $clog2(DIM_MAX);
    localparam int QW         = IXW + FRAC;
    localparam int HALF_W     = (SRC_WIDTH + 1) / 2;
    localparam int HALF_H     = (SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int SBW        = $bits(t_item);
    localparam logic [LW-1:0] LIM_X = LW'(SRC_WIDTH - 1);
    localparam logic [LW-1:0] LIM_Y = LW'(SRC_HEIGHT - 1);

    logic adv;

    // stage 1: products
    logic                 r1_vld;
    t_item                r1_side;
    logic signed [PW-1:0] r1_pcc, r1_pcr, r1_prc, r1_prr, r1_pdc, r1_pdr;
    // stage 2: sums
    logic                 r2_vld;
    t_item                r2_side;
    logic signed [NW-1:0] r2_nx, r2_ny, r2_d;
    // stage 3: magnitudes and signs
    logic                 r3_vld;
    t_item                r3_side;
    logic [NW-1:0]        r3_ax, r3_ay, r3_ad;
    logic                 r3_zx, r3_zy, r3_negx, r3_negy, r3_d0;

    logic    outx, outy;
    t_item   div_in;
    logic    d_vld;
    logic [SBW-1:0] d_sb;
    t_item   dsb;
    logic [QW-1:0] qx, qy;
    logic [IXW-1:0] ix, iy;
    logic [1:0]    wr_bank;
    logic [AW-1:0] wr_addr;
    logic [PIXW-1:0] w_rd [4];

    // stage 6: RAM read
    logic            r6_vld, r6_black, r6_sx, r6_sy;
    logic [FRAC-1:0] r6_fx, r6_fy;
    // stage 7: neighbors and weights
    logic            r7_vld, r7_black;
    logic [PIXW-1:0] r7_p [4];
    logic [32:0]     r7_w [4];
    logic [16:0]     wx [2];
    logic [16:0]     wy [2];
    // stage 8: per-channel terms
    logic            r8_vld, r8_black;
    logic [40:0]     r8_t [12];
    logic [41:0]     acc [3];
    // output register
    logic            r_out_vld, r_out_black;
    logic [PIXW-1:0] r_out_pix;

    assign adv   = !r_out_vld || i_out_ready;
    assign o_pop = adv && i_item_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_item_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side <= i_item;
            r1_pcc  <= $signed(i_coef.cc) * $signed({1'b0, i_item.col});
            r1_pcr  <= $signed(i_coef.cr) * $signed({1'b0, i_item.row});
            r1_prc  <= $signed(i_coef.rc) * $signed({1'b0, i_item.col});
            r1_prr  <= $signed(i_coef.rr) * $signed({1'b0, i_item.row});
            r1_pdc  <= $signed(i_coef.dc) * $signed({1'b0, i_item.col});
            r1_pdr  <= $signed(i_coef.dr) * $signed({1'b0, i_item.row});

            r2_side <= r1_side;
            r2_nx   <= NW'(r1_pcc) + NW'(r1_pcr) + NW'(i_coef.co);
            r2_ny   <= NW'(r1_prc) + NW'(r1_prr) + NW'(i_coef.ro);
            r2_d    <= DEN_ONE + NW'(r1_pdc) + NW'(r1_pdr);

            r3_side <= r2_side;
            r3_ax   <= r2_nx[NW-1] ? NW'(-r2_nx) : r2_nx;
            r3_ay   <= r2_ny[NW-1] ? NW'(-r2_ny) : r2_ny;
            r3_ad   <= r2_d[NW-1] ? NW'(-r2_d) : r2_d;
            r3_zx   <= (r2_nx == '0);
            r3_zy   <= (r2_ny == '0);
            r3_negx <= (r2_nx[NW-1] != r2_d[NW-1]);
            r3_negy <= (r2_ny[NW-1] != r2_d[NW-1]);
            r3_d0   <= (r2_d == '0);
        end
    end

    // a zero numerator maps to zero whatever the denominator sign
    assign outx = !r3_zx && (r3_negx || ({r3_ax, 14'b0} >= LW'(r3_ad) * LIM_X));
    assign outy = !r3_zy && (r3_negy || ({r3_ay, 14'b0} >= LW'(r3_ad) * LIM_Y));

    always_comb begin
        div_in       = r3_side;
        div_in.black = r3_side.black || (!r3_side.load && (r3_d0 || outx || outy));
    end

    pwbr_div #(
        .QW  (QW),
        .SBW (SBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r3_vld),
        .i_sb    (SBW'(div_in)),
        .i_rem_x ({r3_ax, 30'b0}),
        .i_rem_y ({r3_ay, 30'b0}),
        .i_ad    (r3_ad),
        .o_vld   (d_vld),
        .o_sb    (d_sb),
        .o_qx    (qx),
        .o_qy    (qy)
    );

    assign dsb = t_item'(d_sb);
    assign ix  = qx[QW-1:FRAC];
    assign iy  = qy[QW-1:FRAC];

    // banks split by column and row parity so the four neighbors never collide
    assign wr_bank = {dsb.row[0], dsb.col[0]};
    assign wr_addr = AW'((dsb.row >> 1) * HALF_W) + AW'(dsb.col >> 1);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);
        logic [IXW-1:0] cx, cy;
        logic [AW-1:0]  raddr;
        logic           we;

        assign cx    = ix + IXW'(PX != ix[0]);
        assign cy    = iy + IXW'(PY != iy[0]);
        assign raddr = AW'((cy >> 1) * HALF_W) + AW'(cx >> 1);
        assign we    = adv && d_vld && dsb.load && (wr_bank == 2'(b));

        pwbr_ram #(
            .WIDTH (PIXW),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (wr_addr),
            .i_wdata (dsb.pix),
            .i_re    (adv),
            .i_raddr (raddr),
            .o_rdata (w_rd[b])
        );
    end

    assign wx[0] = 17'h10000 - {1'b0, r6_fx};
    assign wx[1] = {1'b0, r6_fx};
    assign wy[0] = 17'h10000 - {1'b0, r6_fy};
    assign wy[1] = {1'b0, r6_fy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r6_vld    <= d_vld && !dsb.load;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r_out_vld <= r8_vld;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = 42'(r8_t[4*c]) + 42'(r8_t[4*c+1]) + 42'(r8_t[4*c+2])
                   + 42'(r8_t[4*c+3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_black <= dsb.black;
            r6_sx    <= ix[0];
            r6_sy    <= iy[0];
            r6_fx    <= qx[FRAC-1:0];
            r6_fy    <= qy[FRAC-1:0];

            r7_black <= r6_black;
            for (int d = 0; d < 4; d++) begin
                r7_p[d] <= w_rd[{r6_sy ^ 1'(d / 2), r6_sx ^ 1'(d % 2)}];
                r7_w[d] <= 33'(wx[d % 2]) * 33'(wy[d / 2]);
            end

            r8_black <= r7_black;
            for (int c = 0; c < 3; c++) begin
                for (int d = 0; d < 4; d++) begin
                    r8_t[4*c+d] <= 41'(r7_p[d][8*c +: 8]) * 41'(r7_w[d]);
                end
            end

            r_out_black <= r8_black;
            for (int c = 0; c < 3; c++) begin
                r_out_pix[8*c +: 8] <= r8_black ? 8'd0 : acc[c][39:32];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_pix;
    assign o_out_user  = r_out_black;

    `PWBR_ASSERT_IMPL(a_index_in_range, d_vld && !dsb.load && !dsb.black, (int'(ix) < SRC_WIDTH - 1) && (int'(iy) < SRC_HEIGHT - 1))
    `PWBR_ASSERT_IMPL(a_load_addr_in_bank, d_vld && dsb.load, int'(wr_addr) < BANK_DEPTH)
    `PWBR_ASSERT_IMPL(a_black_is_zero, r_out_vld && r_out_black, r_out_pix == '0)

endmodule

// File: rtl/projective_warp_bilinear_resampler.sv
// Top level: configuration registers, input front end and datapath.
//
//  channel   dir  fields (tdata/tuser from lowest bit)
//  s_axis    in   tdata: pixel_col, pixel_row, in_blue, in_green, in_red; tuser: operation
//  m_axis    out  tdata: out_blue, out_green, out_red; tuser: outside_source
//  i_cfg_*   in   wr_en, index, wdata (one 32-bit coefficient per write)
//
//  One transaction per cycle unless m_axis stalls, loads and computes alike.
//  The pipelined divider has QW = 16 + clog2(larger source dimension) stages.
//  Reset clears control state only; the source store is undefined until loaded.
//  A held m_axis stalls the whole datapath; a two-entry queue keeps s_axis decoupled.
module projective_warp_bilinear_resampler import pwbr_pkg::*; #(
    parameter int SRC_WIDTH   = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT  = DEF_SRC_HEIGHT,
    parameter int OUT_MAX_DIM = DEF_OUT_MAX_DIM
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pixel_col[9:0], pixel_row[19:10], in_blue[27:20], in_green[35:28], in_red[43:36]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // outside_source
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IW-1:0]      i_cfg_index,
    input  logic [CW-1:0]          i_cfg_wdata
);

    t_coef r_coef;
    t_item item;
    logic  item_vld, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.cc <= COEF_ONE;
            r_coef.cr <= COEF_ZERO;
            r_coef.co <= COEF_ZERO;
            r_coef.rc <= COEF_ZERO;
            r_coef.rr <= COEF_ONE;
            r_coef.ro <= COEF_ZERO;
            r_coef.dc <= COEF_ZERO;
            r_coef.dr <= COEF_ZERO;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_COL_FROM_COL: r_coef.cc <= $signed(i_cfg_wdata);
                REG_COL_FROM_ROW: r_coef.cr <= $signed(i_cfg_wdata);
                REG_COL_OFFSET:   r_coef.co <= $signed(i_cfg_wdata);
                REG_ROW_FROM_COL: r_coef.rc <= $signed(i_cfg_wdata);
                REG_ROW_FROM_ROW: r_coef.rr <= $signed(i_cfg_wdata);
                REG_ROW_OFFSET:   r_coef.ro <= $signed(i_cfg_wdata);
                REG_DEN_FROM_COL: r_coef.dc <= $signed(i_cfg_wdata);
                REG_DEN_FROM_ROW: r_coef.dr <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    pwbr_front #(
        .SRC_WIDTH   (SRC_WIDTH),
        .SRC_HEIGHT  (SRC_HEIGHT),
        .OUT_MAX_DIM (OUT_MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .o_item     (item),
        .o_item_vld (item_vld),
        .i_pop      (pop)
    );

    pwbr_core #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef      (r_coef),
        .i_item      (item),
        .i_item_vld  (item_vld),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule
